[rtl/lsp_pkg.sv]
// Shared types and constants for the LIFO stack with peek.
package lsp_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int WORD_WIDTH_DEFAULT = 32;

    localparam int VALUE_WIDTH = 32;
    localparam int POS_WIDTH   = 7;
    localparam int CAP_WIDTH   = 7;
    localparam int COUNT_WIDTH = 7;

    localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2,
        STATUS_BAD_POS   = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        op_t                           operation;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [POS_WIDTH-1:0]          position;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] data;
        status_t                       status;
        logic [COUNT_WIDTH-1:0]        count;
        logic                          is_full;
        logic                          is_empty;
    } out_item_t;

endpackage

[rtl/lifo_stack_with_peek_unit.sv]
// Top level: LIFO stack of signed words with push, pop, peek and status requests.
// Push, status and every failed request: result registered, valid in the cycle after acceptance.
// Successful pop and peek: the entry RAM's registered read port, then the result register.
// One request in flight: one per cycle unless stalled by out_stall or a pending pop/peek read.
// rst_n (async, low) clears count, capacity (to 64) and handshake state; RAM is not cleared.
module lifo_stack_with_peek_unit #(
    parameter int DEPTH      = lsp_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = lsp_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lsp_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lsp_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsp_pkg::CAP_WIDTH-1:0]       cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > lsp_pkg::POS_WIDTH) ? CW : lsp_pkg::POS_WIDTH;

    lsp_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    lsp_pkg::out_item_t out_data_reg, out_data_next;
    logic [lsp_pkg::CAP_WIDTH-1:0] capacity_reg;

    logic              accept_in;
    logic              read_hit;
    lsp_pkg::status_t  res_status;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_WIDTH-1:0] wr_word;
    logic [WORD_WIDTH-1:0] rd_word;
    logic signed [WORD_WIDTH-1:0] rd_word_s;
    logic signed [63:0] rd_wide;
    logic signed [63:0] value_wide;
    logic [CW-1:0]     pop_count;
    logic [PW-1:0]     peek_index;

    function automatic logic full_at(input logic [CW-1:0] c,
                                     input logic [lsp_pkg::CAP_WIDTH-1:0] cap);
        full_at = (PW'(c) >= PW'(cap)) || (c == CW'(DEPTH));
    endfunction

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != lsp_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    assign value_wide = 64'(in_data.value);
    assign wr_word    = value_wide[WORD_WIDTH-1:0];
    assign rd_word_s  = rd_word;
    assign rd_wide    = 64'(rd_word_s);
    assign pop_count  = count_reg - CW'(1);
    assign peek_index = PW'(count_reg) - PW'(in_data.position);

    lsp_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        read_hit       = 1'b0;
        res_status     = lsp_pkg::STATUS_OK;
        case (state_reg)
            lsp_pkg::ST_IDLE:
            begin
                if (accept_in)
                begin
                    case (in_data.operation)
                        lsp_pkg::OP_PUSH:
                        begin
                            if (full_at(count_reg, capacity_reg))
                            begin
                                res_status = lsp_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        lsp_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = lsp_pkg::STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = pop_count;
                                rd_en      = 1'b1;
                                rd_addr    = pop_count[AW-1:0];
                                read_hit   = 1'b1;
                            end
                        end
                        lsp_pkg::OP_PEEK:
                        begin
                            if ((in_data.position == '0) ||
                                (PW'(in_data.position) > PW'(count_reg)))
                            begin
                                res_status = lsp_pkg::STATUS_BAD_POS;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = peek_index[AW-1:0];
                                read_hit = 1'b1;
                            end
                        end
                        lsp_pkg::OP_STATUS:
                        begin
                            res_status = lsp_pkg::STATUS_OK;
                        end
                        default:
                        begin
                            res_status = lsp_pkg::STATUS_OK;
                        end
                    endcase
                    out_data_next.data     = '0;
                    out_data_next.status   = res_status;
                    out_data_next.count    = lsp_pkg::COUNT_WIDTH'(count_next);
                    out_data_next.is_full  = full_at(count_next, capacity_reg);
                    out_data_next.is_empty = (count_next == '0);
                    out_valid_next         = !read_hit;
                    state_next             = read_hit ? lsp_pkg::ST_READ : lsp_pkg::ST_IDLE;
                end
            end
            lsp_pkg::ST_READ:
            begin
                out_data_next.data = rd_wide[lsp_pkg::VALUE_WIDTH-1:0];
                out_valid_next     = 1'b1;
                state_next         = lsp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsp_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= lsp_pkg::CAPACITY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stack count exceeds depth");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lsp_pkg::ST_READ |-> !out_valid_reg)
        else $error("result register busy during RAM read");

    a_overflow_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && in_data.operation == lsp_pkg::OP_PUSH &&
        full_at(count_reg, capacity_reg) |=> $stable(count_reg))
        else $error("overflowed push changed the count");

    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lsp_pkg::ST_READ |=> out_valid_reg && state_reg == lsp_pkg::ST_IDLE)
        else $error("read did not produce a result");
`endif

endmodule

[rtl/lsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lsp_ram #(
    parameter int WIDTH = lsp_pkg::WORD_WIDTH_DEFAULT,
    parameter int DEPTH = lsp_pkg::DEPTH_DEFAULT,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
